@@ design/histogram_scene_cut_detector_macros.svh @@
// Assertion macros shared by the histogram scene-cut detector.
`ifndef HISTOGRAM_SCENE_CUT_DETECTOR_MACROS_SVH
`define HISTOGRAM_SCENE_CUT_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
`define HSCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hscd assertion failed");
`define HSCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hscd assertion failed");
`else
`define HSCD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HSCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/hscd_pkg.sv @@
// Shared types and constants of the histogram scene-cut detector.
package hscd_pkg;

    localparam int BINS_DEFAULT       = 64;
    localparam int INDEX_BITS_DEFAULT = 24;
    localparam int FIELD_W            = 24;
    localparam int BIN_W              = 16;
    localparam int SUM_W              = 32;
    localparam int DEN_W              = BIN_W + 1;
    localparam int STEP_W             = $clog2(BIN_W);
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [SUM_W-1:0] CUT_THRESHOLD_RESET = 32'd6554;

    typedef enum logic {
        OP_STORE,
        OP_COMPARE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic last_bin;
        logic last_frame;
    } t_item_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_FRAME,
        ST_EMIT_CUT,
        ST_EMIT_END
    } t_back_state;

endpackage

@@ design/histogram_scene_cut_detector.sv @@
// Top level of the chi-square histogram scene-cut detector.
//
// Channel  Direction  Handshake          Payload
// bin      in         i_valid / o_stall  i_frame_index, i_bin_value, i_last_bin, i_last_frame
// shot     out        o_valid / i_stall  o_shot_start, o_shot_length, o_last_shot
// config   in         i_cfg_wr_en        i_cfg_wr_data (cut threshold)
//
// A bin beat of a compared frame passes through fetch, multiply, the bit-serial divider
// (one quotient bit per cycle over 16 steps) and accumulate in the back end.
// A first-frame bin only passes through fetch; a frame end adds the frame and any emit states.
// Reset is synchronous; the previous-histogram RAM has no clearing pass.
// The input stalls only while the two-entry queue is full; an output stall holds the back end.
`include "histogram_scene_cut_detector_macros.svh"

module histogram_scene_cut_detector #(
    parameter int BINS       = hscd_pkg::BINS_DEFAULT,
    parameter int INDEX_BITS = hscd_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [hscd_pkg::FIELD_W-1:0] i_frame_index,
    input  logic [hscd_pkg::BIN_W-1:0]   i_bin_value,
    input  logic                         i_last_bin,
    input  logic                         i_last_frame,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hscd_pkg::FIELD_W-1:0] o_shot_start,
    output logic [hscd_pkg::FIELD_W-1:0] o_shot_length,
    output logic                         o_last_shot,
    input  logic                         i_cfg_wr_en,
    input  logic [hscd_pkg::SUM_W-1:0]   i_cfg_wr_data
);

    localparam int POS_W  = $clog2(BINS);
    localparam int DATA_W = $bits(hscd_pkg::t_item_ctrl) + POS_W
                          + hscd_pkg::FIELD_W + hscd_pkg::BIN_W;

    logic [hscd_pkg::SUM_W-1:0]   r_cut_threshold;
    hscd_pkg::t_queue_status      w_q_status;
    hscd_pkg::t_item_ctrl         w_ctrl;
    logic [POS_W-1:0]             w_pos;
    logic                         w_push;
    logic                         w_pop;
    logic [DATA_W-1:0]            w_head;
    hscd_pkg::t_item_ctrl         w_head_ctrl;
    logic [POS_W-1:0]             w_head_pos;
    logic [hscd_pkg::FIELD_W-1:0] w_head_fidx;
    logic [hscd_pkg::BIN_W-1:0]   w_head_bin;
    logic                         w_back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_threshold <= hscd_pkg::CUT_THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            r_cut_threshold <= i_cfg_wr_data;
        end
    end

    hscd_front #(
        .BINS (BINS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_last_bin   (i_last_bin),
        .i_last_frame (i_last_frame),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_ctrl       (w_ctrl),
        .o_pos        (w_pos)
    );

    hscd_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   ({w_ctrl, w_pos, i_frame_index, i_bin_value}),
        .i_pop    (w_pop),
        .o_data   (w_head),
        .o_status (w_q_status)
    );

    assign {w_head_ctrl, w_head_pos, w_head_fidx, w_head_bin} = w_head;

    hscd_back #(
        .BINS       (BINS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (w_q_status),
        .o_pop           (w_pop),
        .i_ctrl          (w_head_ctrl),
        .i_pos           (w_head_pos),
        .i_fidx          (w_head_fidx),
        .i_bin           (w_head_bin),
        .i_cut_threshold (r_cut_threshold),
        .o_busy          (w_back_busy),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_shot_start    (o_shot_start),
        .o_shot_length   (o_shot_length),
        .o_last_shot     (o_last_shot)
    );

    // A pop needs a queued beat, and a new result only comes out of a busy back end.
    `HSCD_ASSERT_IMPL(a_pop_has_entry, i_clk, i_rst_n, w_pop, !w_q_status.empty)
    `HSCD_ASSERT_IMPL(a_stall_when_full, i_clk, i_rst_n, o_stall, w_q_status.full)
    `HSCD_ASSERT_IMPL(a_result_from_back, i_clk, i_rst_n, $rose(o_valid), $past(w_back_busy))
    `HSCD_ASSERT_NEXT(a_pop_starts_work, i_clk, i_rst_n, w_pop, w_back_busy)

endmodule

@@ design/hscd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hscd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/hscd_front.sv @@
// Front end: accepts bin beats, tracks bin position and first frame, classifies.
module hscd_front #(
    parameter int BINS = hscd_pkg::BINS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_last_bin,
    input  logic                      i_last_frame,
    input  hscd_pkg::t_queue_status   i_q_status,
    output logic                      o_push,
    output hscd_pkg::t_item_ctrl      o_ctrl,
    output logic [$clog2(BINS)-1:0]   o_pos
);

    localparam int POS_W = $clog2(BINS);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             r_seen;
    logic             n_seen;

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    assign o_ctrl.op         = r_seen ? hscd_pkg::OP_COMPARE : hscd_pkg::OP_STORE;
    assign o_ctrl.last_bin   = i_last_bin;
    assign o_ctrl.last_frame = i_last_frame;
    assign o_pos             = r_pos;

    always_comb begin
        n_pos  = r_pos;
        n_seen = r_seen;
        if (o_push) begin
            if (i_last_bin) begin
                n_pos  = '0;
                n_seen = !i_last_frame;
            end else if (r_pos == POS_W'(BINS - 1)) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_seen <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_seen <= n_seen;
        end
    end

endmodule

@@ design/hscd_queue.sv @@
// Short FIFO that decouples the front end from the back end.
module hscd_queue #(
    parameter int DATA_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [DATA_W-1:0]       i_data,
    input  logic                    i_pop,
    output logic [DATA_W-1:0]       o_data,
    output hscd_pkg::t_queue_status o_status
);

    localparam int DEPTH = hscd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/hscd_back.sv @@
// Back end: chi-square term per bin with a bit-serial divider, cut decision, shot output.
module hscd_back #(
    parameter int BINS       = hscd_pkg::BINS_DEFAULT,
    parameter int INDEX_BITS = hscd_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hscd_pkg::t_queue_status           i_q_status,
    output logic                              o_pop,
    input  hscd_pkg::t_item_ctrl              i_ctrl,
    input  logic [$clog2(BINS)-1:0]           i_pos,
    input  logic [hscd_pkg::FIELD_W-1:0]      i_fidx,
    input  logic [hscd_pkg::BIN_W-1:0]        i_bin,
    input  logic [hscd_pkg::SUM_W-1:0]        i_cut_threshold,
    output logic                              o_busy,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [hscd_pkg::FIELD_W-1:0]      o_shot_start,
    output logic [hscd_pkg::FIELD_W-1:0]      o_shot_length,
    output logic                              o_last_shot
);

    localparam int POS_W   = $clog2(BINS);
    localparam int BIN_W   = hscd_pkg::BIN_W;
    localparam int DEN_W   = hscd_pkg::DEN_W;
    localparam int SUM_W   = hscd_pkg::SUM_W;
    localparam int STEP_W  = hscd_pkg::STEP_W;
    localparam int FIELD_W = hscd_pkg::FIELD_W;

    hscd_pkg::t_back_state r_state;
    hscd_pkg::t_back_state n_state;

    hscd_pkg::t_item_ctrl  r_ctrl;
    logic [POS_W-1:0]      r_pos;
    logic [INDEX_BITS-1:0] r_fidx;
    logic [BIN_W-1:0]      r_bin;
    logic [BIN_W-1:0]      r_diff;
    logic [DEN_W-1:0]      r_den;
    logic [DEN_W-1:0]      r_rem;
    logic [BIN_W-1:0]      r_quo;
    logic [STEP_W-1:0]     r_step;
    logic [SUM_W-1:0]      r_sum;
    logic [INDEX_BITS-1:0] r_first;
    logic [INDEX_BITS-1:0] r_start;
    logic [INDEX_BITS-1:0] r_fc;
    logic [INDEX_BITS-1:0] r_cutpos;
    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_out_start;
    logic [FIELD_W-1:0]    r_out_length;
    logic                  r_out_last;

    logic [BIN_W-1:0]      w_prev;
    logic [BIN_W-1:0]      w_diff;
    logic [DEN_W-1:0]      w_den;
    logic [2*BIN_W-1:0]    w_prod;
    logic [DEN_W:0]        w_trial;
    logic [DEN_W:0]        w_trial_sub;
    logic                  w_fit;
    logic [DEN_W-1:0]      w_rem_next;
    logic [SUM_W:0]        w_sum_ext;
    logic [SUM_W-1:0]      w_sum_sat;
    logic                  w_cut;
    logic                  w_slot;
    logic [INDEX_BITS-1:0] w_fc_inc;
    logic [INDEX_BITS-1:0] w_cut_len;
    logic [INDEX_BITS-1:0] w_end_len;
    logic                  w_ram_wr;
    logic                  w_load_cut;
    logic                  w_load_end;

    hscd_ram #(
        .WIDTH (BIN_W),
        .DEPTH (BINS)
    ) u_prev_hist (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr),
        .i_wr_addr (r_pos),
        .i_wr_data (r_bin),
        .i_rd_en   (o_pop),
        .i_rd_addr (i_pos),
        .o_rd_data (w_prev)
    );

    assign w_diff      = (w_prev > r_bin) ? (w_prev - r_bin) : (r_bin - w_prev);
    assign w_den       = DEN_W'(w_prev) + DEN_W'(r_bin) + DEN_W'(1);
    assign w_prod      = (2 * BIN_W)'(r_diff) * (2 * BIN_W)'(r_diff);
    assign w_trial     = {r_rem, r_quo[BIN_W-1]};
    assign w_trial_sub = w_trial - {1'b0, r_den};
    assign w_fit       = (w_trial >= {1'b0, r_den});
    assign w_rem_next  = w_fit ? w_trial_sub[DEN_W-1:0] : w_trial[DEN_W-1:0];
    assign w_sum_ext   = {1'b0, r_sum} + (SUM_W + 1)'(r_quo);
    assign w_sum_sat   = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
    assign w_cut       = (r_sum >> 1) > i_cut_threshold;
    assign w_slot      = !r_out_valid || !i_stall;
    assign w_fc_inc    = (r_fc == '1) ? r_fc : r_fc + 1'b1;
    assign w_cut_len   = r_cutpos - r_start;
    assign w_end_len   = r_fc - r_start;

    always_comb begin
        n_state = r_state;
        case (r_state)
            hscd_pkg::ST_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = hscd_pkg::ST_FETCH;
                end
            end
            hscd_pkg::ST_FETCH: begin
                if (r_ctrl.op == hscd_pkg::OP_COMPARE) begin
                    n_state = hscd_pkg::ST_MUL;
                end else if (r_ctrl.last_bin) begin
                    n_state = hscd_pkg::ST_FRAME;
                end else begin
                    n_state = hscd_pkg::ST_IDLE;
                end
            end
            hscd_pkg::ST_MUL: begin
                n_state = hscd_pkg::ST_DIV;
            end
            hscd_pkg::ST_DIV: begin
                if (r_step == STEP_W'(BIN_W - 1)) begin
                    n_state = hscd_pkg::ST_ACC;
                end
            end
            hscd_pkg::ST_ACC: begin
                n_state = r_ctrl.last_bin ? hscd_pkg::ST_FRAME : hscd_pkg::ST_IDLE;
            end
            hscd_pkg::ST_FRAME: begin
                if (r_ctrl.op == hscd_pkg::OP_COMPARE && w_cut) begin
                    n_state = hscd_pkg::ST_EMIT_CUT;
                end else if (r_ctrl.last_frame) begin
                    n_state = hscd_pkg::ST_EMIT_END;
                end else begin
                    n_state = hscd_pkg::ST_IDLE;
                end
            end
            hscd_pkg::ST_EMIT_CUT: begin
                if (w_slot) begin
                    n_state = r_ctrl.last_frame ? hscd_pkg::ST_EMIT_END
                                                : hscd_pkg::ST_IDLE;
                end
            end
            hscd_pkg::ST_EMIT_END: begin
                if (w_slot) begin
                    n_state = hscd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hscd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        w_ram_wr   = 1'b0;
        w_load_cut = 1'b0;
        w_load_end = 1'b0;
        case (r_state)
            hscd_pkg::ST_IDLE:     o_pop      = !i_q_status.empty;
            hscd_pkg::ST_FETCH:    w_ram_wr   = 1'b1;
            hscd_pkg::ST_EMIT_CUT: w_load_cut = w_slot;
            hscd_pkg::ST_EMIT_END: w_load_end = w_slot;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign o_busy = (r_state != hscd_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctrl <= i_ctrl;
            r_pos  <= i_pos;
            r_fidx <= INDEX_BITS'(i_fidx);
            r_bin  <= i_bin;
        end
        case (r_state)
            hscd_pkg::ST_FETCH: begin
                r_diff <= w_diff;
                r_den  <= w_den;
            end
            hscd_pkg::ST_MUL: begin
                r_rem <= DEN_W'(w_prod[2*BIN_W-1:BIN_W]);
                r_quo <= w_prod[BIN_W-1:0];
            end
            hscd_pkg::ST_DIV: begin
                r_rem <= w_rem_next;
                r_quo <= {r_quo[BIN_W-2:0], w_fit};
            end
            hscd_pkg::ST_FRAME: begin
                r_cutpos <= r_fidx - r_first;
            end
            default: begin
                r_diff <= r_diff;
            end
        endcase
        if (w_load_cut) begin
            r_out_start  <= FIELD_W'(r_start);
            r_out_length <= FIELD_W'(w_cut_len);
            r_out_last   <= !r_ctrl.last_frame;
        end else if (w_load_end) begin
            r_out_start  <= FIELD_W'(r_start);
            r_out_length <= FIELD_W'(w_end_len);
            r_out_last   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hscd_pkg::ST_IDLE;
            r_step      <= '0;
            r_sum       <= '0;
            r_first     <= '0;
            r_start     <= '0;
            r_fc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hscd_pkg::ST_MUL) begin
                r_step <= '0;
            end else if (r_state == hscd_pkg::ST_DIV) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == hscd_pkg::ST_ACC) begin
                r_sum <= w_sum_sat;
            end
            if (r_state == hscd_pkg::ST_FRAME) begin
                r_fc  <= w_fc_inc;
                r_sum <= '0;
                if (r_ctrl.op == hscd_pkg::OP_STORE) begin
                    r_first <= r_fidx;
                    r_start <= '0;
                end
            end
            if (w_load_cut) begin
                r_start <= r_cutpos;
            end
            if (w_load_end) begin
                r_fc    <= '0;
                r_start <= '0;
                r_first <= '0;
            end
            if (w_load_cut || w_load_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_shot_start  = r_out_start;
    assign o_shot_length = r_out_length;
    assign o_last_shot   = r_out_last;

endmodule
